// ===== hdl/lfomc_pkg.sv =====
// ----------------------------------------------------------------------------
// lfomc_pkg
// Shared types and constants of the line-follow / obstacle mode controller.
// ----------------------------------------------------------------------------
package lfomc_pkg;

    // Field widths
    localparam int unsigned DIST_W   = 16;
    localparam int unsigned CENTER_W = 12;  // lane centers and image center
    localparam int unsigned SMOOTH_W = 11;
    localparam int unsigned SUM_W    = 20;
    localparam int unsigned ERR_W    = 17;  // shared PD error width
    localparam int unsigned LANE_W   = 12;
    localparam int unsigned ANG_W    = 11;
    localparam int unsigned LIN_W    = 7;
    localparam int unsigned MODE_W   = 3;
    localparam int unsigned CFG_IX_W = 3;
    localparam int unsigned CFG_D_W  = 16;

    // Controller mode, one-hot
    typedef enum logic [4:0] {
        MODE_SEARCH = 5'b00001,
        MODE_FOLLOW = 5'b00010,
        MODE_WAIT   = 5'b00100,
        MODE_TURN   = 5'b01000,
        MODE_AVOID  = 5'b10000
    } t_mode;

    // Mode codes as shown on the result port
    localparam logic [MODE_W-1:0] CODE_SEARCH = 3'd0;
    localparam logic [MODE_W-1:0] CODE_FOLLOW = 3'd1;
    localparam logic [MODE_W-1:0] CODE_WAIT   = 3'd2;
    localparam logic [MODE_W-1:0] CODE_TURN   = 3'd3;
    localparam logic [MODE_W-1:0] CODE_AVOID  = 3'd4;

    // Configuration register indexes
    typedef enum logic [CFG_IX_W-1:0] {
        CFG_FRONT_STOP = 3'd0,
        CFG_AVOID_CLR  = 3'd1,
        CFG_WAIT_TICKS = 3'd2,
        CFG_STEER_LIM  = 3'd3,
        CFG_FOLLOW_KP  = 3'd4,
        CFG_FOLLOW_KD  = 3'd5,
        CFG_AVOID_KP   = 3'd6,
        CFG_AVOID_KD   = 3'd7
    } t_cfg_idx;

    // Configuration reset values
    localparam logic [15:0] RST_FRONT_STOP = 16'd400;
    localparam logic [15:0] RST_AVOID_CLR  = 16'd200;
    localparam logic [7:0]  RST_WAIT_TICKS = 8'd90;
    localparam logic [9:0]  RST_STEER_LIM  = 10'd500;
    localparam logic [11:0] RST_FOLLOW_KP  = 12'd115;
    localparam logic [15:0] RST_FOLLOW_KD  = 16'd3072;
    localparam logic [11:0] RST_AVOID_KP   = 12'd307;
    localparam logic [15:0] RST_AVOID_KD   = 16'd9216;

    // Fixed commands and limits
    localparam logic [LIN_W-1:0]        LIN_FOLLOW   = 7'd80;
    localparam logic [LIN_W-1:0]        LIN_AVOID    = 7'd50;
    localparam logic signed [ANG_W-1:0] ANG_SEARCH   = 11'sd300;
    localparam logic signed [ANG_W-1:0] ANG_TURN     = 11'sd600;
    localparam logic [DIST_W-1:0]       NO_OBST      = 16'hFFFF;
    localparam logic [SUM_W-1:0]        SUM_MAX      = 20'hFFFFF;
    localparam logic [SUM_W-1:0]        FULL_TURN    = 20'd65536;
    localparam logic [SUM_W-1:0]        QUARTER_TURN = 20'd16384;
    localparam logic [7:0]              WAIT_MAX     = 8'hFF;
    localparam logic [SMOOTH_W-1:0]     SMOOTH_MAX   = 11'd2047;
    localparam logic [16:0]             HALF_WRAP    = 17'd65536;

    // Request to the shared PD unit
    typedef struct packed {
        logic        [11:0]      kp;
        logic        [15:0]      kd;
        logic signed [ERR_W-1:0] err;
        logic signed [ERR_W-1:0] prev;
        logic        [9:0]       limit;
    } t_pd_req;

    // One-hot mode to port code
    function automatic logic [MODE_W-1:0] mode_code(input t_mode m);
        logic [MODE_W-1:0] c;
        case (m)
            MODE_FOLLOW: c = CODE_FOLLOW;
            MODE_WAIT:   c = CODE_WAIT;
            MODE_TURN:   c = CODE_TURN;
            MODE_AVOID:  c = CODE_AVOID;
            default:     c = CODE_SEARCH;
        endcase
        return c;
    endfunction

endpackage

// ===== hdl/line_follow_obstacle_mode_controller_top.sv =====
// ----------------------------------------------------------------------------
// line_follow_obstacle_mode_controller_top
// Five-mode lane follow / obstacle avoid controller, one result per tick.
// ----------------------------------------------------------------------------
// Each control tick gives one result beat. A tick beat lands in an input
// register; once the result register is free or being read, heading
// accumulation, lane filter, the shared PD steer and the mode logic are
// computed in one pass and load the result register, whose beat is then
// valid. The sustained rate is one tick per clock while i_out_ready is
// high, set by the input and result registers handing over in the same clock.
// While a result waits, one more tick fits in the input register; past
// that, a tick is taken only in a clock where the result register frees up.
// Configuration writes are taken every clock out of reset; make them only
// while no tick is in flight.
module line_follow_obstacle_mode_controller_top import lfomc_pkg::*; #(
    parameter int IMG_MID_X = 480
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    // Tick input
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  logic [1:0]               i_line_count,
    input  logic [9:0]               i_left_center_x,
    input  logic [9:0]               i_right_center_x,
    input  logic [DIST_W-1:0]        i_dist_front_mm,
    input  logic [DIST_W-1:0]        i_dist_around_mm,
    input  logic                     i_turn_left,
    input  logic signed [15:0]       i_heading,
    // Result output
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output logic [MODE_W-1:0]        o_mode,
    output logic [LIN_W-1:0]         o_linear_cmd,
    output logic signed [ANG_W-1:0]  o_angular_cmd,
    output logic                     o_line_seen,
    // Configuration writes
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [CFG_IX_W-1:0]      i_cfg_index,
    input  logic [CFG_D_W-1:0]       i_cfg_data
);

    localparam logic [CENTER_W-1:0] IC = CENTER_W'(IMG_MID_X);
    localparam logic [SMOOTH_W-1:0] SMOOTH_RST =
        (IMG_MID_X > 2047) ? SMOOTH_MAX : SMOOTH_W'(IMG_MID_X);

    // Configuration registers
    logic [15:0] r_front_stop, r_avoid_clr, r_follow_kd, r_avoid_kd;
    logic [7:0]  r_wait_ticks;
    logic [9:0]  r_steer_lim;
    logic [11:0] r_follow_kp, r_avoid_kp;

    // Input register
    logic                r_in_valid;
    logic [1:0]          r_in_count;
    logic [9:0]          r_in_left, r_in_right;
    logic [DIST_W-1:0]   r_in_front, r_in_around;
    logic                r_in_tleft;
    logic signed [15:0]  r_in_heading;

    // Controller state
    t_mode                    r_mode, n_mode;
    logic [7:0]               r_wait_cnt, n_wait_cnt;
    logic [SUM_W-1:0]         r_turn_sum, n_turn_sum;
    logic signed [15:0]       r_last_heading;
    logic                     r_heading_valid;
    logic [SMOOTH_W-1:0]      r_smooth, n_smooth;
    logic signed [LANE_W-1:0] r_prev_lane, n_prev_lane;
    logic signed [ERR_W-1:0]  r_prev_gap, n_prev_gap;
    logic                     r_avoid_side, n_avoid_side;

    // Result register
    logic                     r_out_valid;
    logic [MODE_W-1:0]        r_out_mode;
    logic [LIN_W-1:0]         r_out_lin;
    logic signed [ANG_W-1:0]  r_out_ang;
    logic                     r_out_seen;

    logic                     fire;
    logic                     seen;
    logic [15:0]              hd_diff;
    logic [16:0]              hd_mag;
    logic [SUM_W:0]           sum_ext;
    logic [SUM_W-1:0]         acc_sum;
    logic [CENTER_W-1:0]      lx, rx, mid;
    logic [19:0]              sm_full;
    logic [11:0]              sm_q;
    logic signed [12:0]       lane_e13;
    logic signed [LANE_W-1:0] lane_e;
    logic signed [ERR_W-1:0]  gap_e;
    t_pd_req                  pd_req;
    logic signed [ANG_W-1:0]  pd_steer;
    logic                     front_block, front_clear, around_clear;
    logic [7:0]               wait_inc;
    logic [LIN_W-1:0]         n_lin;
    logic signed [ANG_W-1:0]  n_ang;

    // Handshakes
    assign fire        = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = i_rst_n && (!r_in_valid || fire);
    assign o_cfg_ready = i_rst_n;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front_stop <= RST_FRONT_STOP;
            r_avoid_clr  <= RST_AVOID_CLR;
            r_wait_ticks <= RST_WAIT_TICKS;
            r_steer_lim  <= RST_STEER_LIM;
            r_follow_kp  <= RST_FOLLOW_KP;
            r_follow_kd  <= RST_FOLLOW_KD;
            r_avoid_kp   <= RST_AVOID_KP;
            r_avoid_kd   <= RST_AVOID_KD;
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_FRONT_STOP: r_front_stop <= i_cfg_data;
                CFG_AVOID_CLR:  r_avoid_clr  <= i_cfg_data;
                CFG_WAIT_TICKS: r_wait_ticks <= i_cfg_data[7:0];
                CFG_STEER_LIM:  r_steer_lim  <= i_cfg_data[9:0];
                CFG_FOLLOW_KP:  r_follow_kp  <= i_cfg_data[11:0];
                CFG_FOLLOW_KD:  r_follow_kd  <= i_cfg_data;
                CFG_AVOID_KP:   r_avoid_kp   <= i_cfg_data[11:0];
                CFG_AVOID_KD:   r_avoid_kd   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_count   <= i_line_count;
            r_in_left    <= i_left_center_x;
            r_in_right   <= i_right_center_x;
            r_in_front   <= i_dist_front_mm;
            r_in_around  <= i_dist_around_mm;
            r_in_tleft   <= i_turn_left;
            r_in_heading <= i_heading;
        end
    end

    // Heading accumulation, lane filter and loop errors
    always_comb begin
        seen    = (r_in_count != 2'd0);
        hd_diff = 16'(r_in_heading - r_last_heading);
        hd_mag  = hd_diff[15] ? (HALF_WRAP - {1'b0, hd_diff}) : {1'b0, hd_diff};
        sum_ext = {1'b0, r_turn_sum} + {{(SUM_W-16){1'b0}}, hd_mag};
        if (!r_heading_valid) begin
            acc_sum = '0;
        end else if (sum_ext[SUM_W]) begin
            acc_sum = SUM_MAX;
        end else begin
            acc_sum = sum_ext[SUM_W-1:0];
        end

        // raw lane center
        lx = {2'b0, r_in_left};
        rx = {2'b0, r_in_right};
        case (r_in_count)
            2'd0: mid = IC;
            2'd1: mid = (lx > IC) ? ((lx + (lx << 1)) >> 1) : (lx >> 1);
            default: mid = (lx + rx) >> 1;
        endcase

        // 77/256 old + 179/256 new
        sm_full = 20'(r_smooth) * 20'd77 + 20'(mid) * 20'd179;
        sm_q    = sm_full[19:8];
        n_smooth = (sm_q > 12'(SMOOTH_MAX)) ? SMOOTH_MAX : sm_q[SMOOTH_W-1:0];

        lane_e13 = $signed({1'b0, IC}) - $signed({2'b0, n_smooth});
        if (lane_e13 > 13'sd2047) begin
            lane_e = 12'sd2047;
        end else if (lane_e13 < -13'sd2048) begin
            lane_e = -12'sd2048;
        end else begin
            lane_e = lane_e13[LANE_W-1:0];
        end

        gap_e = $signed({1'b0, r_in_around}) - $signed({1'b0, r_avoid_clr});

        // one PD unit: lane loop in follow, gap loop otherwise
        pd_req.limit = r_steer_lim;
        if (r_mode == MODE_FOLLOW) begin
            pd_req.kp   = r_follow_kp;
            pd_req.kd   = r_follow_kd;
            pd_req.err  = ERR_W'(lane_e);
            pd_req.prev = ERR_W'(r_prev_lane);
        end else begin
            pd_req.kp   = r_avoid_kp;
            pd_req.kd   = r_avoid_kd;
            pd_req.err  = gap_e;
            pd_req.prev = r_prev_gap;
        end
    end

    lfomc_pd u_pd (
        .i_req   (pd_req),
        .o_steer (pd_steer)
    );

    // Mode logic
    always_comb begin
        front_block  = (r_in_front < r_front_stop) && (r_in_front != NO_OBST);
        front_clear  = (r_in_front == NO_OBST) || (r_in_front > r_avoid_clr);
        around_clear = (r_in_around == NO_OBST) || (r_in_around > r_avoid_clr);
        wait_inc     = (r_wait_cnt == WAIT_MAX) ? WAIT_MAX : r_wait_cnt + 8'd1;

        n_mode       = r_mode;
        n_wait_cnt   = r_wait_cnt;
        n_turn_sum   = acc_sum;
        n_avoid_side = r_avoid_side;
        n_prev_lane  = (r_mode == MODE_FOLLOW) ? lane_e : r_prev_lane;
        n_prev_gap   = r_prev_gap;
        n_lin        = '0;
        n_ang        = '0;

        case (r_mode)
            MODE_FOLLOW: begin
                if (front_block) begin
                    n_mode     = MODE_WAIT;
                    n_wait_cnt = '0;
                end else if (seen) begin
                    n_lin = LIN_FOLLOW;
                    n_ang = pd_steer;
                end else begin
                    n_mode     = MODE_SEARCH;
                    n_turn_sum = '0;
                end
            end
            MODE_WAIT: begin
                if (!front_block) begin
                    n_mode = MODE_FOLLOW;
                end else begin
                    n_wait_cnt = wait_inc;
                    if (wait_inc >= r_wait_ticks) begin
                        n_mode       = MODE_TURN;
                        n_turn_sum   = '0;
                        n_avoid_side = r_in_tleft;
                    end
                end
            end
            MODE_TURN: begin
                if (acc_sum < QUARTER_TURN) begin
                    n_ang = r_avoid_side ? ANG_TURN : -ANG_TURN;
                end else begin
                    n_mode     = MODE_AVOID;
                    n_turn_sum = '0;
                end
            end
            MODE_AVOID: begin
                if (seen && around_clear) begin
                    n_mode = MODE_FOLLOW;
                end else if (front_clear) begin
                    n_lin      = LIN_AVOID;
                    n_ang      = r_avoid_side ? -pd_steer : pd_steer;
                    n_prev_gap = gap_e;
                end
            end
            default: begin
                n_mode = MODE_SEARCH;
                if (seen) begin
                    n_mode     = MODE_FOLLOW;
                    n_turn_sum = '0;
                end else if (acc_sum < FULL_TURN) begin
                    n_ang = ANG_SEARCH;
                end
            end
        endcase
    end

    // State update per tick
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode          <= MODE_SEARCH;
            r_wait_cnt      <= '0;
            r_turn_sum      <= '0;
            r_last_heading  <= '0;
            r_heading_valid <= 1'b0;
            r_smooth        <= SMOOTH_RST;
            r_prev_lane     <= '0;
            r_prev_gap      <= '0;
            r_avoid_side    <= 1'b0;
        end else if (fire) begin
            r_mode          <= n_mode;
            r_wait_cnt      <= n_wait_cnt;
            r_turn_sum      <= n_turn_sum;
            r_last_heading  <= r_in_heading;
            r_heading_valid <= 1'b1;
            r_smooth        <= n_smooth;
            r_prev_lane     <= n_prev_lane;
            r_prev_gap      <= n_prev_gap;
            r_avoid_side    <= n_avoid_side;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out_mode <= mode_code(n_mode);
            r_out_lin  <= n_lin;
            r_out_ang  <= n_ang;
            r_out_seen <= seen;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_mode        = r_out_mode;
    assign o_linear_cmd  = r_out_lin;
    assign o_angular_cmd = r_out_ang;
    assign o_line_seen   = r_out_seen;

endmodule

// ===== hdl/lfomc_pd.sv =====
// ----------------------------------------------------------------------------
// lfomc_pd
// Shared per-tick PD steer: floor((kp*e + kd*(e-prev))/256), clamped to
// +-limit. Serves the lane loop in follow and the gap loop in avoid.
// ----------------------------------------------------------------------------
module lfomc_pd import lfomc_pkg::*; (
    input  t_pd_req                  i_req,
    output logic signed [ANG_W-1:0]  o_steer
);

    logic signed [ERR_W:0]   diff;
    logic signed [29:0]      p_prod;
    logic signed [34:0]      d_prod;
    logic signed [35:0]      sum;
    logic signed [27:0]      scaled;
    logic signed [27:0]      lim;
    logic signed [27:0]      clamped;

    // Products and sum
    always_comb begin
        diff   = (ERR_W+1)'(i_req.err) - (ERR_W+1)'(i_req.prev);
        p_prod = $signed({1'b0, i_req.kp}) * i_req.err;
        d_prod = $signed({1'b0, i_req.kd}) * diff;
        sum    = 36'(p_prod) + 36'(d_prod);
    end

    // Floor divide by 256, then clamp
    always_comb begin
        scaled = sum[35:8];
        lim    = $signed({18'b0, i_req.limit});
        if (scaled > lim) begin
            clamped = lim;
        end else if (scaled < -lim) begin
            clamped = -lim;
        end else begin
            clamped = scaled;
        end
        o_steer = clamped[ANG_W-1:0];
    end

endmodule

// ===== hdl/lfomc_checker.sv =====
// ----------------------------------------------------------------------------
// lfomc_checker
// Port-level checks on the result channel of the mode controller.
// ----------------------------------------------------------------------------
module lfomc_checker import lfomc_pkg::*; (
    input logic                     i_clk,
    input logic                     i_rst_n,
    input logic                     o_out_valid,
    input logic                     i_out_ready,
    input logic [MODE_W-1:0]        o_mode,
    input logic [LIN_W-1:0]         o_linear_cmd,
    input logic signed [ANG_W-1:0]  o_angular_cmd,
    input logic                     o_line_seen
);

    // No result beat right after reset
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // A stalled result beat holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            o_out_valid && $stable(o_mode) && $stable(o_linear_cmd)
            && $stable(o_angular_cmd) && $stable(o_line_seen))
        else $error("stalled result changed");

    // Follow speed only while following a seen line
    a_follow_speed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_linear_cmd == LIN_FOLLOW |->
            o_mode == CODE_FOLLOW && o_line_seen)
        else $error("follow speed outside follow");

    // Waiting means standing still
    a_wait_still: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_mode == CODE_WAIT |->
            o_linear_cmd == '0 && o_angular_cmd == '0)
        else $error("motion while waiting");

    // Turning is in place: zero on the entry tick, else the fixed rate
    a_turn_rate: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_mode == CODE_TURN |->
            o_linear_cmd == '0
            && (o_angular_cmd == '0 || o_angular_cmd == ANG_TURN
                || o_angular_cmd == -ANG_TURN))
        else $error("bad turn command");

endmodule

bind line_follow_obstacle_mode_controller_top lfomc_checker u_lfomc_checker (.*);
